// ===== hdl/fpd_pkg.sv =====
// Shared codes and types for the linked-list queue with delete by key.
package fpd_pkg;

   // Operation codes carried in the request tuser.
   localparam logic [1:0] MODE_PUSH   = 2'd0;
   localparam logic [1:0] MODE_POP    = 2'd1;
   localparam logic [1:0] MODE_DELETE = 2'd2;
   localparam logic [1:0] MODE_QUERY  = 2'd3;

   // Status codes carried in the response tuser.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_EMPTY   = 2'd2;
   localparam logic [1:0] STATUS_MISSING = 2'd3;

   // Widths of the fixed payload fields.
   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned OCCUPANCY_W = 7;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_PUSH_RD,
      ST_PUSH_WR,
      ST_PUSH_LINK,
      ST_POP_RD,
      ST_POP_USE,
      ST_WALK_RD,
      ST_WALK_CMP,
      ST_UNLINK,
      ST_RELEASE,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/fifo_pool_with_delete_by_key_top.sv =====
// Top level of the linked-list identifier queue with push, pop, delete and query.
//
// The block keeps an ordered queue of 32-bit identifiers in a pool of POOL_SIZE
// linked nodes, with unused nodes held on a spare list. Each request word carries
// an operation in tuser (push, pop, delete first match, query) and an identifier
// or key in tdata; each request gives exactly one response word with a status, the
// popped identifier and the queue occupancy. One request is worked on at a time and
// the request side is not ready meanwhile. Push reads the spare head, stores the
// identifier and makes the node the queue tail; pop reads the head, advances past it
// and releases it to the spare list; a failing push or pop goes straight to the
// response. Delete and query walk the queue through the value and link memories,
// one node at a time on their single read port, up to the first match or the tail;
// a delete then unlinks the matched node and releases it. After reset the block runs
// a clearing pass that builds the initial spare list in the link memory; requests
// are not accepted during it. A finished response waits in an output register, so
// the next request is taken while it is still pending.
module fifo_pool_with_delete_by_key_top #(
   parameter int unsigned POOL_SIZE = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] item_value
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] popped_value, [38:32] occupancy, [39] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   import fpd_pkg::*;

   localparam int unsigned IW = $clog2(POOL_SIZE);
   localparam int unsigned CW = $clog2(POOL_SIZE + 1);
   localparam logic [IW-1:0] LAST_NODE = IW'(POOL_SIZE - 1);

   // Next node index in pool order, wrapping at the end.
   function automatic logic [IW-1:0] next_index(input logic [IW-1:0] idx);
      return (idx == LAST_NODE) ? '0 : IW'(idx + 1'b1);
   endfunction

   state_type            state_ff, state_in;
   logic [1:0]           mode_ff, mode_in;
   logic [VALUE_W-1:0]   key_ff, key_in;
   logic [IW-1:0]        cur_ff, cur_in;
   logic [IW-1:0]        prev_ff, prev_in;
   logic                 has_prev_ff, has_prev_in;
   logic [CW-1:0]        steps_ff, steps_in;
   logic [IW-1:0]        nxt_ff, nxt_in;
   logic [IW-1:0]        init_ff, init_in;
   logic [IW-1:0]        qfirst_ff, qfirst_in;
   logic [IW-1:0]        qlast_ff, qlast_in;
   logic [CW-1:0]        qcount_ff, qcount_in;
   logic [IW-1:0]        sfirst_ff, sfirst_in;
   logic [IW-1:0]        slast_ff, slast_in;
   logic [CW-1:0]        scount_ff, scount_in;
   logic [1:0]           status_ff, status_in;
   logic [VALUE_W-1:0]   popped_ff, popped_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]   rsp_popped_ff, rsp_popped_in;
   logic [OCCUPANCY_W-1:0] rsp_occ_ff, rsp_occ_in;

   // Memory ports.
   logic                 val_we;
   logic [IW-1:0]        val_waddr;
   logic [VALUE_W-1:0]   val_wdata;
   logic [VALUE_W-1:0]   val_rdata;
   logic                 link_we;
   logic [IW-1:0]        link_waddr;
   logic [IW-1:0]        link_wdata;
   logic [IW-1:0]        link_rdata;
   logic [IW-1:0]        rd_addr;

   fpd_ram #(.WIDTH(VALUE_W), .DEPTH(POOL_SIZE)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_waddr),
      .wr_data (val_wdata),
      .rd_addr (rd_addr),
      .rd_data (val_rdata)
   );

   fpd_ram #(.WIDTH(IW), .DEPTH(POOL_SIZE)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (rd_addr),
      .rd_data (link_rdata)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_ff      <= '0;
         qfirst_ff    <= '0;
         qlast_ff     <= '0;
         qcount_ff    <= '0;
         sfirst_ff    <= '0;
         slast_ff     <= LAST_NODE;
         scount_ff    <= CW'(POOL_SIZE);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         qfirst_ff    <= qfirst_in;
         qlast_ff     <= qlast_in;
         qcount_ff    <= qcount_in;
         sfirst_ff    <= sfirst_in;
         slast_ff     <= slast_in;
         scount_ff    <= scount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      has_prev_ff   <= has_prev_in;
      steps_ff      <= steps_in;
      nxt_ff        <= nxt_in;
      status_ff     <= status_in;
      popped_ff     <= popped_in;
      rsp_status_ff <= rsp_status_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // Sequencer: next state, list updates and memory accesses.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      has_prev_in   = has_prev_ff;
      steps_in      = steps_ff;
      nxt_in        = nxt_ff;
      init_in       = init_ff;
      qfirst_in     = qfirst_ff;
      qlast_in      = qlast_ff;
      qcount_in     = qcount_ff;
      sfirst_in     = sfirst_ff;
      slast_in      = slast_ff;
      scount_in     = scount_ff;
      status_in     = status_ff;
      popped_in     = popped_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_popped_in = rsp_popped_ff;
      rsp_occ_in    = rsp_occ_ff;
      val_we        = 1'b0;
      val_waddr     = cur_ff;
      val_wdata     = key_ff;
      link_we       = 1'b0;
      link_waddr    = cur_ff;
      link_wdata    = '0;
      rd_addr       = cur_ff;
      req_tready    = 1'b0;

      case (state_ff)
         // Clearing pass: each node links to the next one in pool order.
         ST_INIT: begin
            link_we    = 1'b1;
            link_waddr = init_ff;
            link_wdata = next_index(init_ff);
            init_in    = next_index(init_ff);
            if (init_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end

         // Take a request word and check the cases that fail at once.
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               mode_in     = req_tuser;
               key_in      = req_tdata;
               popped_in   = '0;
               status_in   = STATUS_OK;
               cur_in      = qfirst_ff;
               has_prev_in = 1'b0;
               steps_in    = '0;
               case (req_tuser)
                  MODE_PUSH: begin
                     if (scount_ff == '0) begin
                        status_in = STATUS_FULL;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_PUSH_RD;
                     end
                  end
                  MODE_POP: begin
                     if (qcount_ff == '0) begin
                        status_in = STATUS_EMPTY;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_POP_RD;
                     end
                  end
                  default: begin
                     status_in = STATUS_MISSING;
                     state_in  = ST_WALK_RD;
                  end
               endcase
            end
         end

         // Push: fetch the spare head's link.
         ST_PUSH_RD: begin
            rd_addr  = sfirst_ff;
            state_in = ST_PUSH_WR;
         end

         // Push: take the spare head, store the identifier and make it the tail.
         ST_PUSH_WR: begin
            cur_in     = sfirst_ff;
            sfirst_in  = link_rdata;
            scount_in  = scount_ff - 1'b1;
            val_we     = 1'b1;
            val_waddr  = sfirst_ff;
            link_we    = 1'b1;
            link_waddr = sfirst_ff;
            link_wdata = '0;
            if (qcount_ff == '0) begin
               qfirst_in = sfirst_ff;
               qlast_in  = sfirst_ff;
               qcount_in = qcount_ff + 1'b1;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_PUSH_LINK;
            end
         end

         // Push: link the old tail to the new node.
         ST_PUSH_LINK: begin
            link_we    = 1'b1;
            link_waddr = qlast_ff;
            link_wdata = cur_ff;
            qlast_in   = cur_ff;
            qcount_in  = qcount_ff + 1'b1;
            state_in   = ST_DONE;
         end

         // Pop: fetch the head's value and link.
         ST_POP_RD: begin
            rd_addr  = qfirst_ff;
            state_in = ST_POP_USE;
         end

         // Pop: return the head and advance past it.
         ST_POP_USE: begin
            popped_in = val_rdata;
            qfirst_in = link_rdata;
            qcount_in = qcount_ff - 1'b1;
            cur_in    = qfirst_ff;
            state_in  = ST_RELEASE;
         end

         // Walk: stop after the last queued node, else fetch the current one.
         ST_WALK_RD: begin
            if (steps_ff == qcount_ff) begin
               state_in = ST_DONE;
            end else begin
               rd_addr  = cur_ff;
               state_in = ST_WALK_CMP;
            end
         end

         // Walk: compare the node with the key and step on if it differs.
         ST_WALK_CMP: begin
            if (val_rdata == key_ff) begin
               status_in = STATUS_OK;
               nxt_in    = link_rdata;
               state_in  = (mode_ff == MODE_DELETE) ? ST_UNLINK : ST_DONE;
            end else begin
               prev_in     = cur_ff;
               has_prev_in = 1'b1;
               cur_in      = link_rdata;
               steps_in    = steps_ff + 1'b1;
               state_in    = ST_WALK_RD;
            end
         end

         // Delete: bypass the found node; its predecessor may become the tail.
         ST_UNLINK: begin
            if (!has_prev_ff) begin
               qfirst_in = nxt_ff;
            end else begin
               link_we    = 1'b1;
               link_waddr = prev_ff;
               link_wdata = nxt_ff;
               if (cur_ff == qlast_ff) begin
                  qlast_in = prev_ff;
               end
            end
            qcount_in = qcount_ff - 1'b1;
            state_in  = ST_RELEASE;
         end

         // Append the freed node to the spare list.
         ST_RELEASE: begin
            if (scount_ff == '0) begin
               sfirst_in = cur_ff;
            end else begin
               link_we    = 1'b1;
               link_waddr = slast_ff;
               link_wdata = cur_ff;
            end
            slast_in  = cur_ff;
            scount_in = scount_ff + 1'b1;
            state_in  = ST_DONE;
         end

         // Hand the result to the output register once it is free.
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_popped_in = popped_ff;
               rsp_occ_in    = OCCUPANCY_W'(qcount_ff);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response word.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_occ_ff, rsp_popped_ff};

endmodule

// ===== hdl/fpd_ram.sv =====
// Single-port-write, single-port-read memory with a registered read.
module fpd_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data valid in the cycle after the address.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
